// ===== rtl/scancode_to_ascii_key_fifo_top_defines.svh =====
// Assertion macros used by the checker file of the scancode key FIFO.
// No dependencies.
`ifndef SCANCODE_TO_ASCII_KEY_FIFO_TOP_DEFINES_SVH
`define SCANCODE_TO_ASCII_KEY_FIFO_TOP_DEFINES_SVH

// Check a property on the rising clock edge, skipped while reset is high.
`define SCKF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define SCKF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sckf_pkg.sv =====
// Types, constants and the set-1 keymap for the scancode key FIFO.
// No dependencies.
package sckf_pkg;

  localparam int FIFO_DEPTH = 256;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = PTR_W + 1;
  localparam int FILL_MAX   = (FIFO_DEPTH - 1 > 255) ? 255 : FIFO_DEPTH - 1;

  localparam int MAP_SIZE   = 58;
  localparam int MAP_IDX_W  = $clog2(MAP_SIZE);

  localparam logic CMD_SCANCODE = 1'b0;
  localparam logic CMD_READ     = 1'b1;

  localparam logic [6:0] ASCII_NONE = 7'h00;
  localparam logic [6:0] ASCII_BS   = 7'h08;
  localparam logic [6:0] ASCII_TAB  = 7'h09;
  localparam logic [6:0] ASCII_LF   = 7'h0A;
  localparam logic [6:0] ASCII_STAR = 7'h2A;
  localparam logic [6:0] ASCII_SPC  = 7'h20;

  localparam logic [6:0] KEYMAP [MAP_SIZE] = '{
    ASCII_NONE, ASCII_NONE, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, ASCII_BS, ASCII_TAB,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, ASCII_LF, ASCII_NONE, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, ASCII_NONE, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, ASCII_NONE, ASCII_STAR,
    ASCII_NONE, ASCII_SPC
  };

  typedef struct packed {
    logic       command;
    logic [7:0] scancode;
  } item_t;

  typedef struct packed {
    logic [6:0]  char_out;
    logic        char_valid;
    logic        stored;
    logic        dropped_full;
    logic [31:0] event_total;
    logic [7:0]  fill_level;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [6:0]       wdata;
    logic [PTR_W-1:0] raddr;
  } ram_req_t;

  function automatic logic [6:0] keymap_lookup(input logic [7:0] code);
    logic [6:0] ch;
    ch = ASCII_NONE;
    if (32'(code) < MAP_SIZE) begin
      ch = KEYMAP[code[MAP_IDX_W-1:0]];
    end
    return ch;
  endfunction

  function automatic logic [7:0] fill_sat(input logic [CNT_W-1:0] n);
    logic [7:0] f;
    if (32'(n) > 32'd255) begin
      f = 8'd255;
    end else begin
      f = 8'(n);
    end
    return f;
  endfunction

endpackage

// ===== rtl/sckf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sckf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sckf_core.sv =====
// Pointer, counter and keymap logic with the result register.
// Depends on sckf_pkg; drives the character RAM through a ram_req_t.
module sckf_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  sckf_pkg::item_t  item,
  input  logic [6:0]       rdata,
  output sckf_pkg::ram_req_t ram_req,
  output logic             strobe,
  output sckf_pkg::result_t result
);
  import sckf_pkg::*;

  logic [PTR_W-1:0] wp, wp_next, wp_inc;
  logic [PTR_W-1:0] rp, rp_next, rp_inc;
  logic [31:0]      count, count_next;
  logic [6:0]       ascii;
  logic             is_event, push_try, full, push, drop, pop;
  logic [CNT_W-1:0] fill;

  logic             strobe_q;
  logic             pop_q, stored_q, drop_q;
  logic [31:0]      total_q;
  logic [7:0]       fill_q;

  always_comb begin
    wp_inc   = (wp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp + PTR_W'(1);
    rp_inc   = (rp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp + PTR_W'(1);
    ascii    = keymap_lookup(item.scancode);
    is_event = (item.command == CMD_SCANCODE);
    push_try = is_event && (ascii != ASCII_NONE);
    full     = (wp_inc == rp);
    push     = push_try && !full;
    drop     = push_try && full;
    pop      = (item.command == CMD_READ) && (wp != rp);

    wp_next    = wp;
    rp_next    = rp;
    count_next = count;
    if (take) begin
      if (push) begin
        wp_next = wp_inc;
      end
      if (pop) begin
        rp_next = rp_inc;
      end
      if (is_event) begin
        count_next = count + 32'd1;
      end
    end

    if (wp_next >= rp_next) begin
      fill = {1'b0, wp_next} - {1'b0, rp_next};
    end else begin
      fill = {1'b0, wp_next} + CNT_W'(FIFO_DEPTH) - {1'b0, rp_next};
    end

    ram_req.we    = take && push;
    ram_req.waddr = wp;
    ram_req.wdata = ascii;
    ram_req.raddr = rp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      rp       <= '0;
      count    <= '0;
      strobe_q <= 1'b0;
      pop_q    <= 1'b0;
    end else begin
      wp       <= wp_next;
      rp       <= rp_next;
      count    <= count_next;
      strobe_q <= take;
      pop_q    <= take && pop;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stored_q <= push;
      drop_q   <= drop;
      total_q  <= count_next;
      fill_q   <= fill_sat(fill);
    end
  end

  assign strobe = strobe_q;

  always_comb begin
    result.char_out     = pop_q ? rdata : ASCII_NONE;
    result.char_valid   = pop_q;
    result.stored       = stored_q;
    result.dropped_full = drop_q;
    result.event_total  = total_q;
    result.fill_level   = fill_q;
  end

endmodule

// ===== rtl/scancode_to_ascii_key_fifo_top.sv =====
// Top level of the set-1 scancode to ASCII key FIFO.
// Depends on sckf_pkg, sckf_core and sckf_ram.
//
//  channel  | handshake         | payload  | accepted when
//  ---------+-------------------+----------+-----------------------------
//  command  | start / busy      | item     | start high, busy low
//  result   | strobe            | result   | edge ending the strobe cycle
//
// One item per cycle while busy is low; each result shows the cycle after
// its item is taken, from the registered read port of the character RAM.
// busy is high only while rst is high; the FIFO needs no clearing pass.
// The receiver cannot stall; results appear in item order, one per item.
module scancode_to_ascii_key_fifo_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sckf_pkg::item_t   item,
  output logic              strobe,
  output sckf_pkg::result_t result
);
  import sckf_pkg::*;

  logic       take;
  ram_req_t   ram_req;
  logic [6:0] rdata;

  assign busy = rst;
  assign take = start && !busy;

  sckf_core u_core (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .item    (item),
    .rdata   (rdata),
    .ram_req (ram_req),
    .strobe  (strobe),
    .result  (result)
  );

  sckf_ram #(
    .WIDTH (7),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (rdata)
  );

endmodule

// ===== rtl/sckf_checker.sv =====
// Port-level checks for the scancode key FIFO, bound to the top level.
// Depends on sckf_pkg and scancode_to_ascii_key_fifo_top_defines.svh.
`include "scancode_to_ascii_key_fifo_top_defines.svh"

module sckf_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input sckf_pkg::item_t   item,
  input logic              strobe,
  input sckf_pkg::result_t result
);
  import sckf_pkg::*;

  `SCKF_ASSERT(a_one_result, clk, rst, 1'b1 |=> (strobe == $past(start && !busy)), "result strobe does not follow item")
  `SCKF_ASSERT(a_flags_excl, clk, rst, strobe |-> $onehot0({result.char_valid, result.stored, result.dropped_full}), "more than one outcome flag")
  `SCKF_ASSERT(a_read_flags, clk, rst, (strobe && $past(item.command) == CMD_READ) |-> (!result.stored && !result.dropped_full), "read item reports a push")
  `SCKF_ASSERT(a_event_flags, clk, rst, (strobe && $past(item.command) == CMD_SCANCODE) |-> (!result.char_valid && result.char_out == ASCII_NONE), "scancode item reports a character")
  `SCKF_ASSERT(a_drop_full, clk, rst, (strobe && result.dropped_full) |-> (result.fill_level == 8'(FILL_MAX)), "drop reported while FIFO not full")

endmodule

bind scancode_to_ascii_key_fifo_top sckf_checker u_sckf_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking bench for the scancode key FIFO: a directed table, then random fill, drain
// and mixed bursts, results checked against the table or a local key buffer model.
// Depends on sckf_pkg and scancode_to_ascii_key_fifo_top.
module tb_top;
  import sckf_pkg::*;

  localparam int RANDOM_ITEMS = 1750;
  localparam int ROWS         = 25;

  typedef struct packed {
    logic    typed;
    item_t   stim;
    result_t want;
  } key_row_t;

  localparam key_row_t KEY_ROWS [ROWS] = '{
    '{1'b1, '{CMD_READ,     8'h00}, '{ASCII_NONE, 1'b0, 1'b0, 1'b0, 32'd0,  8'd0}},
    '{1'b1, '{CMD_SCANCODE, 8'h00}, '{ASCII_NONE, 1'b0, 1'b0, 1'b0, 32'd1,  8'd0}},
    '{1'b1, '{CMD_SCANCODE, 8'h02}, '{ASCII_NONE, 1'b0, 1'b1, 1'b0, 32'd2,  8'd1}},
    '{1'b1, '{CMD_SCANCODE, 8'h82}, '{ASCII_NONE, 1'b0, 1'b0, 1'b0, 32'd3,  8'd1}},
    '{1'b1, '{CMD_SCANCODE, 8'hFF}, '{ASCII_NONE, 1'b0, 1'b0, 1'b0, 32'd4,  8'd1}},
    '{1'b1, '{CMD_SCANCODE, 8'h80}, '{ASCII_NONE, 1'b0, 1'b0, 1'b0, 32'd5,  8'd1}},
    '{1'b1, '{CMD_SCANCODE, 8'h3A}, '{ASCII_NONE, 1'b0, 1'b0, 1'b0, 32'd6,  8'd1}},
    '{1'b1, '{CMD_SCANCODE, 8'h7F}, '{ASCII_NONE, 1'b0, 1'b0, 1'b0, 32'd7,  8'd1}},
    '{1'b1, '{CMD_READ,     8'hFF}, '{7'h31,      1'b1, 1'b0, 1'b0, 32'd7,  8'd0}},
    '{1'b1, '{CMD_READ,     8'h02}, '{ASCII_NONE, 1'b0, 1'b0, 1'b0, 32'd7,  8'd0}},
    '{1'b1, '{CMD_SCANCODE, 8'h39}, '{ASCII_NONE, 1'b0, 1'b1, 1'b0, 32'd8,  8'd1}},
    '{1'b1, '{CMD_SCANCODE, 8'h37}, '{ASCII_NONE, 1'b0, 1'b1, 1'b0, 32'd9,  8'd2}},
    '{1'b1, '{CMD_SCANCODE, 8'h0E}, '{ASCII_NONE, 1'b0, 1'b1, 1'b0, 32'd10, 8'd3}},
    '{1'b1, '{CMD_SCANCODE, 8'h0F}, '{ASCII_NONE, 1'b0, 1'b1, 1'b0, 32'd11, 8'd4}},
    '{1'b1, '{CMD_SCANCODE, 8'h1C}, '{ASCII_NONE, 1'b0, 1'b1, 1'b0, 32'd12, 8'd5}},
    '{1'b1, '{CMD_SCANCODE, 8'h1D}, '{ASCII_NONE, 1'b0, 1'b0, 1'b0, 32'd13, 8'd5}},
    '{1'b1, '{CMD_SCANCODE, 8'h38}, '{ASCII_NONE, 1'b0, 1'b0, 1'b0, 32'd14, 8'd5}},
    '{1'b1, '{CMD_SCANCODE, 8'h36}, '{ASCII_NONE, 1'b0, 1'b0, 1'b0, 32'd15, 8'd5}},
    '{1'b1, '{CMD_SCANCODE, 8'h01}, '{ASCII_NONE, 1'b0, 1'b0, 1'b0, 32'd16, 8'd5}},
    '{1'b1, '{CMD_READ,     8'h55}, '{ASCII_SPC,  1'b1, 1'b0, 1'b0, 32'd16, 8'd4}},
    '{1'b0, '{CMD_SCANCODE, 8'h29}, '0},
    '{1'b0, '{CMD_SCANCODE, 8'h2B}, '0},
    '{1'b0, '{CMD_READ,     8'hAA}, '0},
    '{1'b0, '{CMD_READ,     8'h00}, '0},
    '{1'b0, '{CMD_SCANCODE, 8'h35}, '0}
  };

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  item_t   item;
  logic    strobe;
  result_t result;

  logic [6:0]  key_store [FIFO_DEPTH];
  int unsigned head_idx;
  int unsigned tail_idx;
  logic [31:0] events_seen;
  result_t     pending_results [$];
  int unsigned fail_count = 0;

  scancode_to_ascii_key_fifo_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [6:0] ascii_of(input logic [7:0] code);
    string      num_keys;
    string      upper_keys;
    string      home_keys;
    string      lower_keys;
    logic [6:0] ch;
    num_keys   = "1234567890-=";
    upper_keys = "qwertyuiop[]";
    home_keys  = "asdfghjkl;'";
    lower_keys = "\\zxcvbnm,./";
    if (code >= 8'h02 && code <= 8'h0D) begin
      ch = 7'(num_keys[code - 8'h02]);
    end else if (code >= 8'h10 && code <= 8'h1B) begin
      ch = 7'(upper_keys[code - 8'h10]);
    end else if (code >= 8'h1E && code <= 8'h28) begin
      ch = 7'(home_keys[code - 8'h1E]);
    end else if (code >= 8'h2B && code <= 8'h35) begin
      ch = 7'(lower_keys[code - 8'h2B]);
    end else begin
      case (code)
        8'h0E:   ch = ASCII_BS;
        8'h0F:   ch = ASCII_TAB;
        8'h1C:   ch = ASCII_LF;
        8'h29:   ch = 7'h60;
        8'h37:   ch = ASCII_STAR;
        8'h39:   ch = ASCII_SPC;
        default: ch = ASCII_NONE;
      endcase
    end
    return ch;
  endfunction

  function automatic result_t apply_key_item(input item_t it);
    result_t     r;
    logic [6:0]  ch;
    int unsigned next_idx;
    int unsigned held;
    r = '0;
    if (it.command == CMD_SCANCODE) begin
      events_seen = events_seen + 32'd1;
      ch = ascii_of(it.scancode);
      if (ch != ASCII_NONE) begin
        next_idx = (head_idx + 1) % FIFO_DEPTH;
        if (next_idx != tail_idx) begin
          key_store[head_idx] = ch;
          head_idx = next_idx;
          r.stored = 1'b1;
        end else begin
          r.dropped_full = 1'b1;
        end
      end
    end else if (head_idx != tail_idx) begin
      r.char_out   = key_store[tail_idx];
      r.char_valid = 1'b1;
      tail_idx = (tail_idx + 1) % FIFO_DEPTH;
    end
    held = (head_idx + FIFO_DEPTH - tail_idx) % FIFO_DEPTH;
    r.event_total = events_seen;
    r.fill_level  = (held > 255) ? 8'd255 : 8'(held);
    return r;
  endfunction

  function automatic int unsigned pick_gap(input bit steady);
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic item_t random_key_item(input int unsigned read_pct);
    item_t       it;
    int unsigned roll;
    it.scancode = 8'($urandom_range(0, 255));
    it.command  = ($urandom_range(0, 99) < read_pct) ? CMD_READ : CMD_SCANCODE;
    if (it.command == CMD_SCANCODE) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        do begin
          it.scancode = 8'($urandom_range(0, MAP_SIZE - 1));
        end while (ascii_of(it.scancode) == ASCII_NONE);
      end else if (roll < 90) begin
        it.scancode[7] = 1'b1;
      end
    end
    return it;
  endfunction

  task automatic send_key_item(input item_t it, input int unsigned gap, input logic typed,
                               input result_t want);
    result_t predicted;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = apply_key_item(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && strobe !== 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (result.char_out !== want.char_out) begin
          $display("%0t: char_out expected %0h actual %0h", $time, want.char_out,
                   result.char_out);
          fail_count++;
        end
        if (result.char_valid !== want.char_valid) begin
          $display("%0t: char_valid expected %0b actual %0b", $time, want.char_valid,
                   result.char_valid);
          fail_count++;
        end
        if (result.stored !== want.stored) begin
          $display("%0t: stored expected %0b actual %0b", $time, want.stored, result.stored);
          fail_count++;
        end
        if (result.dropped_full !== want.dropped_full) begin
          $display("%0t: dropped_full expected %0b actual %0b", $time, want.dropped_full,
                   result.dropped_full);
          fail_count++;
        end
        if (result.event_total !== want.event_total) begin
          $display("%0t: event_total expected %0d actual %0d", $time, want.event_total,
                   result.event_total);
          fail_count++;
        end
        if (result.fill_level !== want.fill_level) begin
          $display("%0t: fill_level expected %0d actual %0d", $time, want.fill_level,
                   result.fill_level);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned burst_len;
    int unsigned read_pct;
    int unsigned kind;
    bit          steady;
    rst         = 1'b1;
    start       = 1'b0;
    item        = '0;
    head_idx    = 0;
    tail_idx    = 0;
    events_seen = '0;
    sent        = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (KEY_ROWS[i]) begin
      send_key_item(KEY_ROWS[i].stim, pick_gap(1'b0), KEY_ROWS[i].typed, KEY_ROWS[i].want);
    end

    // fill past full, then hold until every result is back
    for (int i = 0; i < 400; i++) begin
      send_key_item(random_key_item(0), pick_gap(1'b0), 1'b0, '0);
      sent++;
    end
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    for (int i = 0; i < 300; i++) begin
      send_key_item(random_key_item(92), pick_gap(1'b0), 1'b0, '0);
      sent++;
    end

    while (sent < RANDOM_ITEMS) begin
      kind   = $urandom_range(0, 2);
      steady = ($urandom_range(0, 3) == 0);
      case (kind)
        0: begin
          burst_len = $urandom_range(100, 300);
          read_pct  = 5;
        end
        1: begin
          burst_len = $urandom_range(100, 300);
          read_pct  = 95;
        end
        default: begin
          burst_len = $urandom_range(20, 120);
          read_pct  = $urandom_range(10, 90);
        end
      endcase
      for (int j = 0; j < burst_len && sent < RANDOM_ITEMS; j++) begin
        send_key_item(random_key_item(read_pct), pick_gap(steady), 1'b0, '0);
        sent++;
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sckf_pkg.sv
rtl/sckf_ram.sv
rtl/sckf_core.sv
rtl/scancode_to_ascii_key_fifo_top.sv
rtl/sckf_checker.sv
tb/tb_top.sv
